/* src/oas_pkg.sv */
`default_nettype none
package oas_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int NUM_CH      = 5;
	localparam int RAW_BITS    = 14;
	localparam int SC_BITS     = 9;

	typedef logic [2:0]             chan_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [RAW_BITS-1:0]    raw_t;
	typedef logic [SC_BITS-1:0]     scaled_t;

	localparam chan_t LAST_CH = chan_t'(NUM_CH - 1);

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_V_SET = 3'd0,
		CFG_V_OUT = 3'd1,
		CFG_I_SET = 3'd2,
		CFG_I_OUT = 3'd3,
		CFG_V_IN  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		chan_t v_set;
		chan_t v_out;
		chan_t i_set;
		chan_t i_out;
		chan_t v_in;
	} chan_map_t;

	// front-end view of an item at accept time
	typedef struct packed {
		logic  done;
		chan_t ch;
		chan_t next_ch;
		raw_t  acc;
	} seq_info_t;

	typedef struct packed {
		logic  raw_re;
		chan_t raw_addr;
		logic  sc_re;
		chan_t sc_addr;
	} store_rd_t;

	typedef struct packed {
		logic    raw_we;
		logic    sc_we;
		chan_t   addr;
		raw_t    raw;
		scaled_t sc;
	} store_wr_t;

endpackage
`default_nettype wire

/* src/oversampled_adc_scanner.sv */
// Five-channel round-robin oversampler: 16 samples per channel, then raw sum and scaled value.
// Pipeline: stage 1 registers the item and table read, then scaling loads the output register.
// Throughput: one item per cycle unless the output stalls; raw/scaled tables are read at most
//   once per item, written per completed block, with forwarding when a read hits that write.
// Reset: accumulator, sample count and mux go to 0, tables read as 0 through per-entry
//   valid bits, channel map returns to 0..4; no clearing pass.
`default_nettype none
module oversampled_adc_scanner
	import oas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [9:0] sample, [12:10] read_channel, [15:13] zero
	input  wire logic        s_tuser,   // [0] command
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [2:0] next_channel, [5:3] channel, [19:6] raw_sum,
	                                    // [28:20] scaled, [31:29] zero
	output logic             m_tuser,   // [0] done_res
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [2:0]  cfg_data
);

	// channel role map
	chan_map_t map_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q.v_set <= chan_t'(0);
			map_q.v_out <= chan_t'(1);
			map_q.i_set <= chan_t'(2);
			map_q.i_out <= chan_t'(3);
			map_q.v_in  <= chan_t'(4);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_V_SET: map_q.v_set <= cfg_data;
				CFG_V_OUT: map_q.v_out <= cfg_data;
				CFG_I_SET: map_q.i_set <= cfg_data;
				CFG_I_OUT: map_q.i_out <= cfg_data;
				CFG_V_IN:  map_q.v_in  <= cfg_data;
				default:   ; // writes past the map are dropped
			endcase
		end
	end

	// flow control: whole pipe moves when the output register can take a result
	logic advance, accept;
	cmd_t    in_cmd;
	sample_t in_sample;
	chan_t   in_rd;

	assign advance   = !m_tvalid || m_tready;
	assign s_tready  = advance;
	assign accept    = s_tvalid && s_tready;
	assign in_cmd    = cmd_t'(s_tuser);
	assign in_sample = s_tdata[SAMPLE_BITS-1:0];
	assign in_rd     = s_tdata[12:10];

	// stage 0: accumulate, issue table reads
	seq_info_t info;

	oas_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (in_cmd),
		.sample (in_sample),
		.info   (info)
	);

	logic rd_ok, iout_ok;
	store_rd_t st_rd;
	store_wr_t st_wr;
	raw_t      rd_raw;
	scaled_t   rd_sc;

	always_comb begin
		rd_ok   = (in_rd <= LAST_CH);
		iout_ok = (map_q.i_out <= LAST_CH);
		if (in_cmd == CMD_READ) begin
			st_rd.raw_re   = accept && rd_ok;
			st_rd.raw_addr = in_rd;
			st_rd.sc_re    = accept && rd_ok;
			st_rd.sc_addr  = in_rd;
		end else begin
			// completed block: correction source and old scaled value of this channel
			st_rd.raw_re   = accept && info.done && iout_ok;
			st_rd.raw_addr = map_q.i_out;
			st_rd.sc_re    = accept && info.done;
			st_rd.sc_addr  = info.ch;
		end
	end

	oas_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (st_rd),
		.wr     (st_wr),
		.rd_raw (rd_raw),
		.rd_sc  (rd_sc)
	);

	// stage 1 registers
	logic  valid_s1;
	cmd_t  cmd_s1;
	logic  done_s1, rd_ok_s1, corr_ok_s1;
	chan_t ch_s1, next_s1;
	raw_t  acc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= in_cmd;
			done_s1    <= info.done;
			rd_ok_s1   <= rd_ok;
			corr_ok_s1 <= iout_ok;
			ch_s1      <= (in_cmd == CMD_READ) ? in_rd : info.ch;
			next_s1    <= info.next_ch;
			acc_s1     <= info.acc;
		end
	end

	// stage 1: scale and write back
	raw_t    iout_raw;
	scaled_t new_sc;
	logic    has_role;

	// output-current raw comes from this very block when the roles share a channel
	assign iout_raw = (map_q.i_out == ch_s1) ? acc_s1 : rd_raw;

	oas_scale u_scale (
		.map      (map_q),
		.ch       (ch_s1),
		.raw      (acc_s1),
		.iout_raw (iout_raw),
		.corr_ok  (corr_ok_s1),
		.scaled   (new_sc),
		.has_role (has_role)
	);

	logic    blk_s1;
	raw_t    res_raw;
	scaled_t res_sc;

	always_comb begin
		blk_s1       = valid_s1 && (cmd_s1 == CMD_SAMPLE) && done_s1;
		st_wr.raw_we = blk_s1 && advance;
		st_wr.sc_we  = blk_s1 && advance && has_role;
		st_wr.addr   = ch_s1;
		st_wr.raw    = acc_s1;
		st_wr.sc     = new_sc;

		if (cmd_s1 == CMD_READ) begin
			res_raw = rd_ok_s1 ? rd_raw : raw_t'(0);
			res_sc  = rd_ok_s1 ? rd_sc : scaled_t'(0);
		end else if (done_s1) begin
			res_raw = acc_s1;
			res_sc  = has_role ? new_sc : rd_sc;  // no role: table value stays
		end else begin
			res_raw = '0;
			res_sc  = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (advance)
			m_tvalid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {3'b000, res_sc, res_raw, ch_s1, next_s1};
			m_tuser <= (cmd_s1 == CMD_SAMPLE) && done_s1;
		end
	end

endmodule
`default_nettype wire

/* src/oas_seq.sv */
`default_nettype none
module oas_seq
	import oas_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire cmd_t      cmd,
	input  wire sample_t   sample,
	output seq_info_t      info
);

	raw_t       acc_q;
	logic [3:0] cnt_q;
	chan_t      mux_q;

	logic done;
	chan_t wrap_ch;

	always_comb begin
		done    = (cmd == CMD_SAMPLE) && (cnt_q == 4'hF);
		wrap_ch = (mux_q >= LAST_CH) ? chan_t'(0) : chan_t'(mux_q + chan_t'(1));
		info.done    = done;
		info.ch      = mux_q;
		info.next_ch = done ? wrap_ch : mux_q;
		info.acc     = raw_t'(acc_q + raw_t'(sample));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			mux_q <= '0;
		end else if (accept && (cmd == CMD_SAMPLE)) begin
			acc_q <= done ? raw_t'(0) : info.acc;
			cnt_q <= 4'(cnt_q + 4'd1);
			mux_q <= info.next_ch;
		end
	end

endmodule
`default_nettype wire

/* src/oas_store.sv */
`default_nettype none
module oas_store
	import oas_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire store_rd_t rd,
	input  wire store_wr_t wr,
	output raw_t           rd_raw,
	output scaled_t        rd_sc
);

	raw_t    raw_mem [NUM_CH];
	scaled_t sc_mem  [NUM_CH];

	logic [NUM_CH-1:0] raw_vld_q, sc_vld_q;
	logic raw_ok_q, raw_fwd_q, sc_ok_q, sc_fwd_q;
	raw_t    raw_dat_q, raw_fwd_dat_q;
	scaled_t sc_dat_q, sc_fwd_dat_q;

	logic raw_hit, sc_hit;

	// write in the same cycle as a read of that entry: take the new data
	assign raw_hit = wr.raw_we && (wr.addr == rd.raw_addr);
	assign sc_hit  = wr.sc_we && (wr.addr == rd.sc_addr);

	always_ff @(posedge clk) begin
		if (wr.raw_we)
			raw_mem[wr.addr] <= wr.raw;
		if (wr.sc_we)
			sc_mem[wr.addr] <= wr.sc;
		if (rd.raw_re) begin
			raw_dat_q     <= raw_mem[rd.raw_addr];
			raw_fwd_dat_q <= wr.raw;
		end
		if (rd.sc_re) begin
			sc_dat_q     <= sc_mem[rd.sc_addr];
			sc_fwd_dat_q <= wr.sc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_vld_q <= '0;
			sc_vld_q  <= '0;
			raw_ok_q  <= 1'b0;
			raw_fwd_q <= 1'b0;
			sc_ok_q   <= 1'b0;
			sc_fwd_q  <= 1'b0;
		end else begin
			if (wr.raw_we)
				raw_vld_q[wr.addr] <= 1'b1;
			if (wr.sc_we)
				sc_vld_q[wr.addr] <= 1'b1;
			if (rd.raw_re) begin
				raw_ok_q  <= raw_vld_q[rd.raw_addr];
				raw_fwd_q <= raw_hit;
			end
			if (rd.sc_re) begin
				sc_ok_q  <= sc_vld_q[rd.sc_addr];
				sc_fwd_q <= sc_hit;
			end
		end
	end

	assign rd_raw = raw_fwd_q ? raw_fwd_dat_q : (raw_ok_q ? raw_dat_q : raw_t'(0));
	assign rd_sc  = sc_fwd_q ? sc_fwd_dat_q : (sc_ok_q ? sc_dat_q : scaled_t'(0));

endmodule
`default_nettype wire

/* src/oas_scale.sv */
`default_nettype none
module oas_scale
	import oas_pkg::*;
(
	input  wire chan_map_t map,
	input  wire chan_t     ch,
	input  wire raw_t      raw,
	input  wire raw_t      iout_raw,
	input  wire logic      corr_ok,
	output scaled_t        scaled,
	output logic           has_role
);

	function automatic scaled_t sat_sub(scaled_t a, scaled_t b);
		return (a > b) ? scaled_t'(a - b) : scaled_t'(0);
	endfunction

	logic [9:0]  r, ri;
	logic [15:0] p_v75, p_i60, p_v53;
	logic [13:0] p_r9;
	logic [14:0] p_i30, p_corr;
	scaled_t     corr;

	always_comb begin
		r      = raw[13:4];
		ri     = iout_raw[13:4];
		p_v75  = 16'(r[9:1]) * 16'd75;
		p_r9   = 14'(r) * 14'd9;
		p_i30  = 15'(r) * 15'd30;
		p_i60  = 16'(r) * 16'd60;
		p_v53  = 16'(r) * 16'd53;
		p_corr = 15'(ri) * 15'd19;
		corr   = corr_ok ? scaled_t'(p_corr[14:12]) : scaled_t'(0);

		has_role = 1'b1;
		if (ch == map.v_set)
			scaled = sat_sub(p_v75[15:7], scaled_t'(p_r9[13:12]));
		else if (ch == map.v_out)
			scaled = sat_sub(p_v75[15:7], corr);
		else if (ch == map.i_set)
			scaled = sat_sub(scaled_t'(p_i30[14:7]), scaled_t'(r[9]));
		else if (ch == map.i_out)
			scaled = sat_sub(p_i60[15:7], scaled_t'(r[9:8]));
		else if (ch == map.v_in)
			scaled = p_v53[15:7];
		else begin
			scaled   = '0;
			has_role = 1'b0;
		end
	end

endmodule
`default_nettype wire

/* src/oas_checker.sv */
`default_nettype none
module oas_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// empty output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// mux stays in range
	a_mux_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("next channel out of range");

	// completed block advances the mux by one, wrapping at the last channel
	a_mux_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			((m_tdata[5:3] == 3'd4) ? (m_tdata[2:0] == 3'd0)
			                        : (m_tdata[2:0] == 3'(m_tdata[5:3] + 3'd1))))
		else $error("mux did not advance after block");

	// a 16-sample sum of 10-bit samples tops out at 16368
	a_raw_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:6] <= 14'd16368)
		else $error("raw sum above block maximum");

endmodule

bind oversampled_adc_scanner oas_checker u_oas_checker (.*);
`default_nettype wire

/* tb/oversampled_adc_scanner_tb.sv */
`timescale 1ns / 1ps
module oversampled_adc_scanner_tb;
	import oas_pkg::*;

	localparam int IDLE_MAX    = 18;    // longest per-item wait on either side
	localparam int QUIET_LIMIT = 1000;  // cycles with no handshake anywhere before giving up
	localparam int PHASE_ITEMS = 48;    // random items per channel-map setting
	localparam int NUM_PHASES  = 8;
	localparam int BLOCK_LEN   = 16;    // samples per oversampled block

	// Sample "level" for a whole block, so that the averaged values land in
	// interesting places: tiny averages (saturating output voltage), full scale, noise.
	typedef enum int {LVL_FULL, LVL_LOW, LVL_HIGH, LVL_TOP, LVL_FLOOR} level_t;

	// One result item as the block should produce it
	typedef struct packed {
		chan_t   next_ch;
		logic    done;
		chan_t   ch;
		raw_t    raw;
		scaled_t sc;
	} reading_t;

	// Tracks the scanner's state and holds the readings still owed by the block.
	class scan_scoreboard;
		chan_map_t  cmap;
		raw_t       acc;
		logic [3:0] count;
		chan_t      mux;
		raw_t       raw_tab[NUM_CH];
		scaled_t    sc_tab[NUM_CH];
		reading_t   due[$];
		int         errors;

		function new();
			cmap   = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
			acc    = '0;
			count  = '0;
			mux    = '0;
			errors = 0;
			for (int i = 0; i < NUM_CH; i++) begin
				raw_tab[i] = '0;
				sc_tab[i]  = '0;
			end
		endfunction

		function void set_role(cfg_idx_t idx, chan_t val);
			case (idx)
				CFG_V_SET: cmap.v_set = val;
				CFG_V_OUT: cmap.v_out = val;
				CFG_I_SET: cmap.i_set = val;
				CFG_I_OUT: cmap.i_out = val;
				CFG_V_IN:  cmap.v_in  = val;
				default: ;
			endcase
		endfunction

		// Role formula on the averaged value; first matching role wins,
		// a channel with no role keeps its old scaled value.
		function void rescale(int ch);
			int unsigned r, hi, lo;
			r  = raw_tab[ch] / BLOCK_LEN;
			lo = 0;
			if (ch == cmap.v_set) begin
				hi = (r / 2) * 75 / 128;
				lo = r * 9 / 4096;
			end else if (ch == cmap.v_out) begin
				hi = (r / 2) * 75 / 128;
				// current correction from the averaged output-current value
				if (cmap.i_out < NUM_CH)
					lo = (raw_tab[cmap.i_out] / BLOCK_LEN) * 19 / 4096;
			end else if (ch == cmap.i_set) begin
				hi = r * 30 / 128;
				lo = r / 512;
			end else if (ch == cmap.i_out) begin
				hi = r * 60 / 128;
				lo = r / 256;
			end else if (ch == cmap.v_in) begin
				hi = r * 53 / 128;
			end else begin
				return;
			end
			sc_tab[ch] = scaled_t'((hi > lo) ? hi - lo : 0);
		endfunction

		function void note_input(cmd_t cmd, sample_t smp, chan_t rd);
			reading_t e;
			e.done = 1'b0;
			e.raw  = '0;
			e.sc   = '0;
			if (cmd == CMD_SAMPLE) begin
				e.ch  = mux;
				acc   = acc + raw_t'(smp);
				count = count + 1'b1;
				if (count == 0) begin
					if (mux < NUM_CH) begin
						raw_tab[mux] = acc;
						rescale(mux);
						e.raw = raw_tab[mux];
						e.sc  = sc_tab[mux];
					end
					acc    = '0;
					e.done = 1'b1;
					mux    = (mux >= LAST_CH) ? chan_t'(0) : mux + 1'b1;
				end
			end else begin
				e.ch = rd;
				if (rd < NUM_CH) begin
					e.raw = raw_tab[rd];
					e.sc  = sc_tab[rd];
				end
			end
			e.next_ch = mux;
			due.push_back(e);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] data, logic user);
			reading_t e;
			if (due.size() == 0) begin
				$error("result with nothing pending: tdata %h tuser %b", data, user);
				errors++;
				return;
			end
			e = due.pop_front();
			check_field("next_channel", e.next_ch, data[2:0]);
			check_field("done_res", e.done, user);
			check_field("channel", e.ch, data[5:3]);
			check_field("raw_sum", e.raw, data[19:6]);
			check_field("scaled", e.sc, data[28:20]);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;     // [9:0] sample, [12:10] read_channel, [15:13] zero
	logic        s_tuser   = 1'b0;   // [0] command
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;            // [2:0] next_channel, [5:3] channel, [19:6] raw_sum,
	                                 // [28:20] scaled, [31:29] zero
	logic        m_tuser;            // [0] done_res
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [2:0]  cfg_data  = '0;

	scan_scoreboard sb;

	bit     src_idle  = 1'b0;  // sender inserts random gaps
	bit     sink_idle = 1'b0;  // receiver drops tready at random
	int     sink_gap  = 0;
	int     sink_draw;
	int     quiet     = 0;
	int     blk_pos   = 0;
	level_t level     = LVL_FULL;

	oversampled_adc_scanner uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: check every accepted item, then draw how long to hold tready low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tuser);
			sink_draw = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
			m_tready <= (sink_draw == 0);
			sink_gap <= sink_draw;
		end else if (sink_gap > 1) begin
			sink_gap <= sink_gap - 1;
			m_tready <= 1'b0;
		end else begin
			sink_gap <= 0;
			m_tready <= 1'b1;
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("oversampled_adc_scanner_tb NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// One input item. tvalid stays high into the next item when there is no gap,
	// so it is only lowered when a gap is actually inserted.
	task automatic send_item(cmd_t cmd, sample_t smp, chan_t rd);
		int gap;
		gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, rd, smp};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, smp, rd);
	endtask

	// Same for register writes; write_map lowers valid after the last one.
	task automatic write_reg(cfg_idx_t idx, chan_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_role(idx, val);
	endtask

	task automatic write_map(chan_map_t m);
		write_reg(CFG_V_SET, m.v_set);
		write_reg(CFG_V_OUT, m.v_out);
		write_reg(CFG_I_SET, m.i_set);
		write_reg(CFG_I_OUT, m.i_out);
		write_reg(CFG_V_IN, m.v_in);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every result is back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Samples come in blocks of 16 sharing one level, aligned with the mux rotation.
	function automatic sample_t draw_sample();
		if (blk_pos == 0)
			level = level_t'($urandom_range(0, 4));
		blk_pos = (blk_pos + 1) % BLOCK_LEN;
		case (level)
			LVL_LOW:   return sample_t'($urandom_range(0, 31));
			LVL_HIGH:  return sample_t'($urandom_range(992, 1023));
			LVL_TOP:   return '1;
			LVL_FLOOR: return sample_t'($urandom_range(0, 7));
			default:   return sample_t'($urandom);
		endcase
	endfunction

	// Mostly conversion samples (the only way to complete blocks), with reads of
	// any channel, out-of-range ones included, mixed in. Unused fields carry noise.
	task automatic run_random(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 15)
				send_item(CMD_READ, sample_t'($urandom), chan_t'($urandom_range(0, 7)));
			else
				send_item(CMD_SAMPLE, draw_sample(), chan_t'($urandom));
		end
	endtask

	initial begin
		chan_map_t plan;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, back to back: read every index from the cleared tables
		// (5..7 have no channel), then one full-scale block on channel 0
		// and read it back.
		for (int c = 0; c < 8; c++)
			send_item(CMD_READ, '0, chan_t'(c));
		for (int k = 0; k < BLOCK_LEN; k++)
			send_item(CMD_SAMPLE, '1, chan_t'(0));
		send_item(CMD_READ, '1, chan_t'(0));

		// Channel-map settings: default, reversed, all roles on one channel
		// (priority), all out of range (no roles, no correction), partial maps,
		// then random ones.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0:       plan = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
				1:       plan = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
				2:       plan = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
				3:       plan = {3'd7, 3'd7, 3'd7, 3'd7, 3'd7};
				4:       plan = {3'd1, 3'd0, 3'd5, 3'd6, 3'd2};
				5:       plan = {3'd3, 3'd4, 3'd4, 3'd7, 3'd1};
				default: plan = chan_map_t'(15'($urandom));
			endcase
			write_map(plan);
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			run_random(PHASE_ITEMS);
		end

		settle();
		if (sb.errors == 0)
			$display("oversampled_adc_scanner_tb OK");
		else
			$display("oversampled_adc_scanner_tb NOT OK");
		$finish;
	end

endmodule

/* oversampled_adc_scanner.f */
src/oas_pkg.sv
src/oas_seq.sv
src/oas_store.sv
src/oas_scale.sv
src/oversampled_adc_scanner.sv
src/oas_checker.sv
tb/oversampled_adc_scanner_tb.sv
